### rtl/kedle_pkg.sv
// ----------------------------------------------------------------------------
// kedle_pkg
// Shared types and codes for the key escape decoder and line editor.
// ----------------------------------------------------------------------------
package kedle_pkg;

    // Request kinds
    localparam logic [1:0] REQ_KEY   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Command codes
    localparam logic [3:0] ACT_NONE       = 4'd0;
    localparam logic [3:0] ACT_RIGHT      = 4'd1;
    localparam logic [3:0] ACT_LEFT       = 4'd2;
    localparam logic [3:0] ACT_UP         = 4'd3;
    localparam logic [3:0] ACT_DOWN       = 4'd4;
    localparam logic [3:0] ACT_MOVE_LEFT  = 4'd5;
    localparam logic [3:0] ACT_ENTER      = 4'd6;
    localparam logic [3:0] ACT_MOVE_RIGHT = 4'd7;
    localparam logic [3:0] ACT_TYPED      = 4'd8;
    localparam logic [3:0] ACT_QUIT       = 4'd9;

    // Key bytes of interest
    localparam logic [7:0] KEY_QUIT  = 8'h60;  // backquote
    localparam logic [7:0] KEY_ESC   = 8'd27;
    localparam logic [7:0] KEY_LBRK  = 8'd91;
    localparam logic [7:0] KEY_DEL   = 8'd127;
    localparam logic [7:0] KEY_BS    = 8'd8;
    localparam logic [7:0] KEY_TILDE = 8'h7E;
    localparam logic [7:0] KEY_LF    = 8'd10;
    localparam logic [7:0] KEY_CR    = 8'd13;

    // Request payload
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] key_byte;
        logic [4:0] read_index;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [3:0] command;
        logic [5:0] line_length;
        logic [7:0] read_char;
    } t_rsp;

endpackage

### rtl/kedle_ram.sv
// ----------------------------------------------------------------------------
// kedle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kedle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/key_escape_decoder_line_editor_unit.sv
// ----------------------------------------------------------------------------
// key_escape_decoder_line_editor_unit
// Keyboard byte decoder with arrow-key and tilde-ended escape sequences and a
// bounded line buffer held in a RAM.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                payload
//   request   in         i_req_valid/o_req_ready  i_req (t_req)
//   result    out        o_rsp_valid/i_rsp_ready  o_rsp (t_rsp)
//   config    in         i_cfg_we                 i_cfg_wdata (arrow enable)
//
// One request per cycle unless a stalled result blocks it; each result appears in
// the cycle after its request, read data from the registered line RAM read. Escape
// state and line count update in the accept cycle, so requests follow back to back.
// A stalled result holds in the output register (RAM read data holds too);
// requests are still taken whenever that register is empty or being drained.
// Synchronous reset clears escape state, line count and arrow enable; the
// line RAM is not cleared since read data is shown only below the line count.
// ----------------------------------------------------------------------------
module key_escape_decoder_line_editor_unit
    import kedle_pkg::*;
#(
    parameter int LINE_MAX = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(LINE_MAX > 1 ? LINE_MAX : 2);
    localparam int CW = $clog2(LINE_MAX + 1);
    localparam int KW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_SEEN,
        ESC_BRACKET,
        ESC_TILDE
    } t_esc;

    t_esc            r_esc, n_esc;
    logic [CW-1:0]   r_count, n_count;
    logic            r_arrow_en;
    logic            r_rsp_valid;
    logic [3:0]      r_cmd, n_cmd;
    logic [5:0]      r_len;
    logic            r_rd_hit, n_rd_hit;

    logic            accept;
    logic [7:0]      b;
    logic            do_plain;
    logic            is_alnum;
    logic            is_erase;
    logic            wr_en;
    logic [7:0]      ram_rdata;

    assign accept      = i_req_valid && o_req_ready;
    assign o_req_ready = !r_rsp_valid || i_rsp_ready;
    assign b           = i_req.key_byte;

    // Character classes
    assign is_alnum = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
                      (b >= 8'h30 && b <= 8'h39) || (b == 8'h20);
    assign is_erase = (b == KEY_BS) || (b == KEY_DEL);

    // Escape machine and command decode
    always_comb begin
        n_esc    = r_esc;
        n_cmd    = ACT_NONE;
        do_plain = 1'b0;
        if (b == KEY_QUIT) begin
            n_cmd = ACT_QUIT;
        end else if (!r_arrow_en) begin
            n_esc    = ESC_IDLE;
            do_plain = 1'b1;
        end else begin
            case (r_esc)
                ESC_IDLE: begin
                    if (b == KEY_ESC) begin
                        n_esc = ESC_SEEN;
                    end else begin
                        do_plain = 1'b1;
                    end
                end
                ESC_SEEN: begin
                    if (b == KEY_LBRK) begin
                        n_esc = ESC_BRACKET;
                    end else begin
                        n_esc    = ESC_IDLE;
                        do_plain = 1'b1;
                    end
                end
                ESC_BRACKET: begin
                    n_esc = ESC_IDLE;
                    case (b)
                        8'h41: n_cmd = ACT_UP;
                        8'h42: n_cmd = ACT_DOWN;
                        8'h43: n_cmd = ACT_RIGHT;
                        8'h44: n_cmd = ACT_LEFT;
                        8'h31: begin
                            n_cmd = ACT_ENTER;
                            n_esc = ESC_TILDE;
                        end
                        8'h32: begin
                            n_cmd = ACT_MOVE_LEFT;
                            n_esc = ESC_TILDE;
                        end
                        8'h35: begin
                            n_cmd = ACT_MOVE_RIGHT;
                            n_esc = ESC_TILDE;
                        end
                        default: do_plain = 1'b1;
                    endcase
                end
                default: begin
                    n_esc = ESC_IDLE;
                    if (b != KEY_TILDE) begin
                        do_plain = 1'b1;
                    end
                end
            endcase
        end
        if (do_plain && (b == KEY_LF || b == KEY_CR)) begin
            n_cmd = ACT_TYPED;
        end
    end

    // Line edit, clear, and read check per request kind
    always_comb begin
        n_count  = r_count;
        n_rd_hit = 1'b0;
        wr_en    = 1'b0;
        case (i_req.req_type)
            REQ_KEY: begin
                if (do_plain && is_erase) begin
                    if (r_count != '0) begin
                        n_count = r_count - CW'(1);
                    end
                end else if (do_plain && is_alnum && r_count < CW'(LINE_MAX)) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            REQ_CLEAR: n_count = '0;
            REQ_READ:  n_rd_hit = KW'(i_req.read_index) < KW'(r_count);
            default:   n_count = r_count;
        endcase
    end

    kedle_ram #(
        .WIDTH(8),
        .DEPTH(LINE_MAX)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (accept && wr_en),
        .i_waddr (AW'(r_count)),
        .i_wdata (b),
        .i_re    (accept),
        .i_raddr (AW'(i_req.read_index)),
        .o_rdata (ram_rdata)
    );

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc       <= ESC_IDLE;
            r_count     <= '0;
            r_arrow_en  <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_arrow_en <= i_cfg_wdata;
            end
            if (accept) begin
                if (i_req.req_type == REQ_KEY) begin
                    r_esc <= n_esc;
                end
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_cmd    <= (i_req.req_type == REQ_KEY) ? n_cmd : ACT_NONE;
            r_len    <= 6'(n_count);
            r_rd_hit <= n_rd_hit;
        end
    end

    assign o_rsp_valid       = r_rsp_valid;
    assign o_rsp.command     = r_cmd;
    assign o_rsp.line_length = r_len;
    assign o_rsp.read_char   = r_rd_hit ? ram_rdata : 8'd0;

endmodule
